>>> design/f8fp_pkg.sv
// Shared types and constants for the Fletcher-8 frame parser.
// No dependencies; compiled first.
`default_nettype none

package f8fp_pkg;

    // Beat payloads
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [7:0] frame_position;
        logic       in_body;
        logic       frame_end;
        logic [1:0] status;
        logic [7:0] length_seen;
    } t_result;

    // Frame status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_GOOD    = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;
    localparam logic [1:0] ST_BAD_LEN = 2'd3;

    // Position arithmetic is done at this width: wide enough for length + 3
    localparam int CMP_W = 10;

    localparam logic [CMP_W-1:0] POS_HUNT  = 10'd0;
    localparam logic [CMP_W-1:0] POS_SYNC2 = 10'd1;
    localparam logic [CMP_W-1:0] POS_SYNC3 = 10'd2;
    localparam logic [CMP_W-1:0] POS_LEN   = 10'd3;
    localparam logic [CMP_W-1:0] POS_BODY  = 10'd4;
    localparam logic [CMP_W-1:0] LEN_MIN   = 10'd4;

    // Configuration register map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_SYNC_THIRD  = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'd65;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd67;
    localparam logic [7:0] SYNC_THIRD_RST  = 8'd79;

endpackage

`default_nettype wire

>>> design/f8fp_stream_if.sv
// Valid/ready stream interface used for both the byte input and result output.
// Payload type is a parameter; the parser uses types from f8fp_pkg.
`default_nettype none

interface f8fp_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/fletcher8_frame_parser.sv
// Fletcher-8 frame parser: the result beat is registered and appears in the cycle after its input beat is taken;
// throughput 1 beat per cycle while the result side drains; the single result register decides it, and a
// new byte is taken whenever that register is empty or being drained.
// Reset (synchronous, active low) returns to sync hunting, clears the sums and
// restores the default sync bytes; the held check byte is not reset.
// Depends on f8fp_pkg and f8fp_stream_if.
`default_nettype none

module fletcher8_frame_parser #(
    parameter int MAX_FRAME = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    f8fp_stream_if.sink                  i_rx,
    f8fp_stream_if.source                o_res,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [f8fp_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready
);
    import f8fp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME);
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(MAX_FRAME - 4);

    // Configuration
    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_sync_third;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    // Frame state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_len,   n_len;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [7:0]       r_chk,   n_chk;

    // Result stage
    logic    r_res_valid;
    t_result r_res;
    t_result n_res;

    logic             in_acc;
    logic [7:0]       rx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] rx_ext;
    logic [7:0]       sum_a_add;
    logic [7:0]       sum_b_add;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[3:2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_sync_third  <= SYNC_THIRD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SYNC_FIRST:  r_sync_first  <= i_pwdata[7:0];
                REG_SYNC_SECOND: r_sync_second <= i_pwdata[7:0];
                REG_SYNC_THIRD:  r_sync_third  <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC_FIRST:  o_prdata = {24'd0, r_sync_first};
            REG_SYNC_SECOND: o_prdata = {24'd0, r_sync_second};
            REG_SYNC_THIRD:  o_prdata = {24'd0, r_sync_third};
            default:         o_prdata = 32'd0;
        endcase
    end

    // Stream handshake: the result register parts the two sides
    assign i_rx.ready  = !r_res_valid || o_res.ready;
    assign in_acc      = i_rx.valid && i_rx.ready;
    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    assign rx        = i_rx.data.rx_byte;
    assign pos_ext   = CMP_W'(r_pos);
    assign len_ext   = CMP_W'(r_len);
    assign rx_ext    = CMP_W'(rx);
    assign sum_a_add = r_sum_a + rx;
    assign sum_b_add = r_sum_b + sum_a_add;

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_chk   = r_chk;

        n_res.echo_byte      = rx;
        n_res.frame_position = pos_ext[7:0];
        n_res.in_body        = 1'b0;
        n_res.frame_end      = 1'b0;
        n_res.status         = ST_NONE;
        n_res.length_seen    = 8'd0;

        unique case (pos_ext)
            POS_HUNT: begin
                if (rx == r_sync_first) begin
                    n_pos   = POS_W'(POS_SYNC2);
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                end
            end
            POS_SYNC2: begin
                if (rx == r_sync_second) begin
                    n_pos = POS_W'(POS_SYNC3);
                end else begin
                    // wrong byte is not retried as a first sync byte
                    n_pos           = POS_W'(POS_HUNT);
                    n_res.frame_end = 1'b1;
                end
            end
            POS_SYNC3: begin
                if (rx == r_sync_third) begin
                    n_pos   = POS_W'(POS_LEN);
                    n_sum_a = 8'd0;
                    n_sum_b = 8'd0;
                end else begin
                    n_pos           = POS_W'(POS_HUNT);
                    n_res.frame_end = 1'b1;
                end
            end
            POS_LEN: begin
                n_len             = rx;
                n_res.length_seen = rx;
                n_sum_a           = sum_a_add;
                n_sum_b           = sum_b_add;
                if (rx_ext < LEN_MIN || rx_ext > LEN_MAX) begin
                    n_pos           = POS_W'(POS_HUNT);
                    n_res.frame_end = 1'b1;
                    n_res.status    = ST_BAD_LEN;
                end else begin
                    n_pos = POS_W'(POS_BODY);
                end
            end
            default: begin
                n_res.length_seen = r_len;
                if (pos_ext < len_ext + 10'd2) begin
                    n_sum_a       = sum_a_add;
                    n_sum_b       = sum_b_add;
                    n_res.in_body = 1'b1;
                    n_pos         = POS_W'(pos_ext + 10'd1);
                end else if (pos_ext == len_ext + 10'd2) begin
                    // first check byte: held, not summed
                    n_chk = rx;
                    n_pos = POS_W'(pos_ext + 10'd1);
                end else begin
                    n_pos           = POS_W'(POS_HUNT);
                    n_res.frame_end = 1'b1;
                    n_res.status    = (r_chk == r_sum_a && rx == r_sum_b) ? ST_GOOD
                                                                         : ST_BAD_SUM;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= 8'd0;
            r_sum_a     <= 8'd0;
            r_sum_b     <= 8'd0;
            r_res_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_sum_a <= n_sum_a;
                r_sum_b <= n_sum_b;
            end
            if (in_acc) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_chk <= n_chk;
            r_res <= n_res;
        end
    end

`ifndef SYNTH
    // A beat that closes a frame always sends the parser back to hunting
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_res.frame_end |=> r_pos == '0)
        else $error("parser did not return to hunting after frame end");

    // Any status other than none comes with frame end
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.status != ST_NONE |-> r_res.frame_end)
        else $error("status reported without frame end");

    // Body beats only after the length byte
    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.in_body |-> r_res.frame_position >= 8'd4)
        else $error("body flag before length byte");

    // Inside a frame the position never passes the last check byte
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos_ext >= POS_BODY |-> pos_ext <= len_ext + 10'd3)
        else $error("frame position ran past the check bytes");
`endif

endmodule

`default_nettype wire

>>> tb/fletcher8_frame_parser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for fletcher8_frame_parser: directed frames, then random frames.
// Covers good, corrupt, short and broken frames under several sync settings.
// Depends on f8fp_pkg, f8fp_stream_if and the parser RTL.

module fletcher8_frame_parser_test;
    import f8fp_pkg::*;

    localparam int FRAME_MAX       = 256;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int N_PHASES        = 5;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 4;
    localparam int TIMEOUT_CYCLES  = 200000;

    // Register slot past the sync bytes; writes to it must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_dir_row;

    // Default sync A C O. Typed rows carry the obvious answer, the rest go to the predictor.
    localparam t_dir_row DIRECTED [27] = '{
        '{8'hFF, 1'b1, '{8'hFF, 8'd0, 1'b0, 1'b0, ST_NONE, 8'd0}},
        // second sync byte wrong, and it is not retried as a first sync byte
        '{8'h41, 1'b1, '{8'h41, 8'd0, 1'b0, 1'b0, ST_NONE, 8'd0}},
        '{8'h41, 1'b1, '{8'h41, 8'd1, 1'b0, 1'b1, ST_NONE, 8'd0}},
        '{8'h43, 1'b1, '{8'h43, 8'd0, 1'b0, 1'b0, ST_NONE, 8'd0}},
        // third sync byte wrong
        '{8'h41, 1'b0, '0},
        '{8'h43, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 8'd2, 1'b0, 1'b1, ST_NONE, 8'd0}},
        // length too short
        '{8'h41, 1'b0, '0},
        '{8'h43, 1'b0, '0},
        '{8'h4F, 1'b0, '0},
        '{8'h03, 1'b1, '{8'h03, 8'd3, 1'b0, 1'b1, ST_BAD_LEN, 8'h03}},
        // shortest good frame
        '{8'h41, 1'b0, '0},
        '{8'h43, 1'b0, '0},
        '{8'h4F, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h0A, 1'b1, '{8'h0A, 8'd7, 1'b0, 1'b1, ST_GOOD, 8'h04}},
        // second check byte wrong
        '{8'h41, 1'b0, '0},
        '{8'h43, 1'b0, '0},
        '{8'h4F, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, 8'd7, 1'b0, 1'b1, ST_BAD_SUM, 8'h04}}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    f8fp_stream_if #(.T(t_item))   rx_if ();
    f8fp_stream_if #(.T(t_result)) res_if ();

    fletcher8_frame_parser #(.MAX_FRAME(FRAME_MAX)) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_rx      (rx_if),
        .o_res     (res_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #6 clk = ~clk;

    // Parser model state
    logic [7:0]       sync_bytes [3];
    logic [CMP_W-1:0] frame_pos;
    logic [7:0]       frame_len;
    logic [7:0]       sum_lo, sum_hi, check_lo;

    t_result pending_results [$];
    int      fails = 0;
    int      cycles = 0;
    int      send_gap_pct = 0;
    int      recv_gap_pct = 0;
    int      hold_req = 0;

    function automatic void fletcher_add(input logic [7:0] b);
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.echo_byte = b;
        r.frame_position = frame_pos[7:0];
        r.status = ST_NONE;
        case (frame_pos)
            POS_HUNT: if (b == sync_bytes[REG_SYNC_FIRST]) begin
                frame_pos = POS_SYNC2;
                sum_lo = '0;
                sum_hi = '0;
            end
            POS_SYNC2: if (b == sync_bytes[REG_SYNC_SECOND]) begin
                frame_pos = POS_SYNC3;
            end else begin
                frame_pos = POS_HUNT;
                r.frame_end = 1'b1;
            end
            POS_SYNC3: if (b == sync_bytes[REG_SYNC_THIRD]) begin
                frame_pos = POS_LEN;
                sum_lo = '0;
                sum_hi = '0;
            end else begin
                frame_pos = POS_HUNT;
                r.frame_end = 1'b1;
            end
            POS_LEN: begin
                frame_len = b;
                r.length_seen = b;
                fletcher_add(b);
                if (int'(b) < int'(LEN_MIN) || int'(b) > FRAME_MAX - 4) begin
                    frame_pos = POS_HUNT;
                    r.frame_end = 1'b1;
                    r.status = ST_BAD_LEN;
                end else begin
                    frame_pos = POS_BODY;
                end
            end
            default: begin
                r.length_seen = frame_len;
                if (int'(frame_pos) < int'(frame_len) + 2) begin
                    fletcher_add(b);
                    r.in_body = 1'b1;
                    frame_pos = frame_pos + 1'b1;
                end else if (int'(frame_pos) == int'(frame_len) + 2) begin
                    check_lo = b;
                    frame_pos = frame_pos + 1'b1;
                end else begin
                    r.frame_end = 1'b1;
                    r.status = (check_lo == sum_lo && b == sum_hi) ? ST_GOOD : ST_BAD_SUM;
                    frame_pos = POS_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    // One input beat; the expectation is queued at the accepting edge
    task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input t_result want = '0);
        t_result predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            rx_if.valid = 1'b0;
            @(negedge clk);
        end
        rx_if.valid = 1'b1;
        rx_if.data.rx_byte = b;
        do @(posedge clk); while (!rx_if.ready);
        predicted = parse_byte(b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_frame(inout int sent);
        int kind, len, slot;
        logic [7:0] lo, hi, val;
        kind = $urandom_range(99);
        if (kind < 70) begin
            if ($urandom_range(14) == 0)
                len = $urandom_range(1) ? FRAME_MAX - 4 : $urandom_range(FRAME_MAX - 5, 100);
            else if ($urandom_range(5) == 0)
                len = int'(LEN_MIN);
            else
                len = $urandom_range(20, 4);
            for (int i = 0; i < 3; i++) push_byte(sync_bytes[i]);
            lo = 8'(len);
            hi = lo;
            push_byte(lo);
            for (int i = 0; i < len - 2; i++) begin
                val = 8'($urandom);
                push_byte(val);
                lo = lo + val;
                hi = hi + lo;
            end
            case ($urandom_range(5))
                0: lo = lo ^ 8'($urandom_range(255, 1));
                1: hi = hi ^ 8'($urandom_range(255, 1));
                default: ;
            endcase
            push_byte(lo);
            push_byte(hi);
            sent += len + 4;
        end else if (kind < 80) begin
            for (int i = 0; i < 3; i++) push_byte(sync_bytes[i]);
            case ($urandom_range(3))
                0: val = 8'($urandom_range(3));
                1: val = 8'($urandom_range(255, FRAME_MAX - 3));
                default: val = $urandom_range(1) ? 8'd3 : 8'(FRAME_MAX - 3);
            endcase
            push_byte(val);
            sent += 4;
        end else if (kind < 90) begin
            slot = $urandom_range(2, 1);
            for (int i = 0; i < slot; i++) push_byte(sync_bytes[i]);
            push_byte(sync_bytes[slot] ^ 8'($urandom_range(255, 1)));
            sent += slot + 1;
        end else begin
            // line noise, not counted
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_SPARE) begin
            psel = 1'b0;
        end else begin
            sync_bytes[idx] = value;
            // read back
            @(negedge clk);
            penable = 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata[7:0] !== value) begin
                $display("%0t: reg %0d read expected %h got %h", $time, idx, value, prdata[7:0]);
                fails++;
            end
            @(negedge clk);
            psel = 1'b0;
            penable = 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fails++;
        end
    endtask

    // Result side: random stalls plus the occasional long hold-off
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready = 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result expected none got %h", $time, res_if.data);
                fails++;
            end else begin
                want = pending_results.pop_front();
                check_field("echo_byte", want.echo_byte, res_if.data.echo_byte);
                check_field("frame_position", want.frame_position,
                            res_if.data.frame_position);
                check_field("in_body", 8'(want.in_body), 8'(res_if.data.in_body));
                check_field("frame_end", 8'(want.frame_end), 8'(res_if.data.frame_end));
                check_field("status", 8'(want.status), 8'(res_if.data.status));
                check_field("length_seen", want.length_seen, res_if.data.length_seen);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("[fletcher8_frame_parser] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int sent;
        rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sync_bytes[REG_SYNC_FIRST] = SYNC_FIRST_RST;
        sync_bytes[REG_SYNC_SECOND] = SYNC_SECOND_RST;
        sync_bytes[REG_SYNC_THIRD] = SYNC_THIRD_RST;
        frame_pos = POS_HUNT;
        frame_len = '0;
        sum_lo = '0;
        sum_hi = '0;
        check_lo = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < N_PHASES; phase++) begin
            send_gap_pct = (phase < 2) ? 12 : (phase < 4) ? 61 : 0;
            recv_gap_pct = (phase < 2) ? 61 : (phase < 4) ? 12 : 0;
            if (phase == 0) begin
                for (int i = 0; i < $size(DIRECTED); i++)
                    push_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
            end else begin
                wait_drained();
                case (phase)
                    1: begin
                        write_reg(REG_SYNC_FIRST, 8'h00);
                        write_reg(REG_SYNC_SECOND, 8'hFF);
                        write_reg(REG_SYNC_THIRD, 8'h00);
                        write_reg(REG_SPARE, 8'($urandom));
                    end
                    2: begin
                        write_reg(REG_SYNC_FIRST, 8'hFF);
                        write_reg(REG_SYNC_SECOND, 8'hFF);
                        write_reg(REG_SYNC_THIRD, 8'hFF);
                    end
                    3: begin
                        write_reg(REG_SYNC_FIRST, 8'($urandom));
                        write_reg(REG_SYNC_SECOND, 8'($urandom));
                        write_reg(REG_SYNC_THIRD, 8'($urandom));
                    end
                    default: begin
                        write_reg(REG_SYNC_FIRST, SYNC_FIRST_RST);
                        write_reg(REG_SYNC_SECOND, SYNC_SECOND_RST);
                        write_reg(REG_SYNC_THIRD, SYNC_THIRD_RST);
                    end
                endcase
            end
            // long receiver hold-off so the input backs up
            if (phase % 2 == 1) hold_req++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) send_frame(sent);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0) begin
            $display("[fletcher8_frame_parser] OK");
        end else begin
            $display("[fletcher8_frame_parser] ERROR");
        end
        $finish;
    end

endmodule
